/* hdl/ccmsel_pkg.sv */
// Package for the colour correction matrix selector: widths, codes, state type,
// the scan result struct and small helper functions.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package ccmsel_pkg;

	localparam int MAX_SETS_DEF = 8;
	localparam int TEMP_W       = 16;
	localparam int COEF_IN_W    = 23;
	localparam int COEF_OUT_W   = 16;
	localparam int WEIGHT_W     = 17;
	localparam int PROD_W       = COEF_IN_W + WEIGHT_W;
	localparam int NUM_W        = PROD_W + 1;
	localparam int REM_W        = NUM_W + 3;
	localparam int QUOT_W       = 17;
	localparam int SET_IDX_W    = 6;
	localparam int NUM_COEF     = 9;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 4;

	typedef enum logic [1:0] {
		OP_WR_TEMP = 2'd0,
		OP_WR_COEF = 2'd1,
		OP_LOOKUP  = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SET_COUNT  = 1'b0,
		REG_BLEND_MODE = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CMP,
		ST_DECIDE,
		ST_RDA,
		ST_RDB,
		ST_MULB,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic [SET_IDX_W-1:0] best;
		logic                 have_lo;
		logic [SET_IDX_W-1:0] lo;
		logic [TEMP_W-1:0]    lo_t;
		logic                 have_hi;
		logic [SET_IDX_W-1:0] hi;
		logic [TEMP_W-1:0]    hi_t;
	} scan_res_t;

	// Output position row*3+col reads stored position col*3+row.
	function automatic logic [3:0] stored_index(input logic [3:0] pos);
		logic [3:0] row;
		logic [3:0] col;
		row = 4'd0;
		col = 4'd0;
		if (pos >= 4'd6) begin
			row = 4'd2;
		end else if (pos >= 4'd3) begin
			row = 4'd1;
		end
		col = pos - 4'(row * 4'd3);
		return 4'(col * 4'd3) + row;
	endfunction

	function automatic logic signed [COEF_OUT_W-1:0] identity_coef(input logic [3:0] pos);
		if (pos == 4'd0 || pos == 4'd4 || pos == 4'd8) begin
			return 16'sd1024;
		end
		return 16'sd0;
	endfunction

endpackage

/* hdl/ccmsel_req_if.sv */
// Request channel interface: valid/ready plus the fields of one request.
// Depends on ccmsel_pkg for field widths.
`timescale 1ns / 1ps

interface ccmsel_req_if;
	logic                                    valid;
	logic                                    ready;
	logic [1:0]                              op;
	logic [2:0]                              entry;
	logic [3:0]                              coef_index;
	logic [ccmsel_pkg::TEMP_W-1:0]           temperature;
	logic signed [ccmsel_pkg::COEF_IN_W-1:0] coef_value;

	modport source(output valid, op, entry, coef_index, temperature, coef_value, input ready);
	modport sink(input valid, op, entry, coef_index, temperature, coef_value, output ready);
endinterface

/* hdl/ccmsel_rsp_if.sv */
// Response channel interface: valid/ready plus the nine output coefficients.
// Depends on ccmsel_pkg for field widths.
`timescale 1ns / 1ps

interface ccmsel_rsp_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [ccmsel_pkg::COEF_OUT_W-1:0] coef_0;
	logic signed [ccmsel_pkg::COEF_OUT_W-1:0] coef_1;
	logic signed [ccmsel_pkg::COEF_OUT_W-1:0] coef_2;
	logic signed [ccmsel_pkg::COEF_OUT_W-1:0] coef_3;
	logic signed [ccmsel_pkg::COEF_OUT_W-1:0] coef_4;
	logic signed [ccmsel_pkg::COEF_OUT_W-1:0] coef_5;
	logic signed [ccmsel_pkg::COEF_OUT_W-1:0] coef_6;
	logic signed [ccmsel_pkg::COEF_OUT_W-1:0] coef_7;
	logic signed [ccmsel_pkg::COEF_OUT_W-1:0] coef_8;

	modport source(output valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, coef_6,
		coef_7, coef_8, input ready);
	modport sink(input valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, coef_6,
		coef_7, coef_8, output ready);
endinterface

/* hdl/ccmsel_cfg_if.sv */
// Configuration write channel interface: valid/ready, register index and data.
// Depends on ccmsel_pkg for widths.
`timescale 1ns / 1ps

interface ccmsel_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [ccmsel_pkg::CFG_IDX_W-1:0]    index;
	logic [ccmsel_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* hdl/ccm_select_by_cct_core.sv */
// Top level of the colour correction matrix selector: set tables, sequencer,
// shared multiplier. Depends on ccmsel_pkg, the channel interfaces,
// ccmsel_scan and ccmsel_div.
`timescale 1ns / 1ps

// Table writes store a set temperature or one coefficient. A lookup with N valid
// sets first scans the N set temperatures one at a time from their memory, then for
// each of the nine coefficients reads the coefficients of the two sets and
// multiply-accumulates them on the one shared multiplier, and the bit-serial divider
// rounds and saturates the sum. An empty table answers identity. Requests are not
// taken while a lookup is in progress or its result has not been taken.
module ccm_select_by_cct_core #(
	parameter int MAX_SETS = ccmsel_pkg::MAX_SETS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ccmsel_req_if.sink   req,
	ccmsel_rsp_if.source rsp,
	ccmsel_cfg_if.sink   cfg
);

	localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int CNT_W = $clog2(MAX_SETS + 1);
	localparam int DEPTH = MAX_SETS * ccmsel_pkg::NUM_COEF;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = ccmsel_pkg::TEMP_W;
	localparam int CW    = ccmsel_pkg::COEF_IN_W;
	localparam int OW    = ccmsel_pkg::COEF_OUT_W;

	ccmsel_pkg::seq_state_t state_q, state_d;

	logic [TW-1:0]        tmem_q [MAX_SETS];
	logic signed [CW-1:0] cmem_q [DEPTH];
	logic [TW-1:0]        tdat_q;
	logic signed [CW-1:0] cdat_q;

	logic [3:0]           set_count_q;
	logic                 blend_mode_q;
	logic [CNT_W-1:0]     n_eff;

	logic [TW-1:0]        t_q;
	logic [SET_W-1:0]     idx_q;
	logic [SET_W-1:0]     lo_q;
	logic [SET_W-1:0]     hi_q;
	logic [TW-1:0]        wlo_q;
	logic [TW-1:0]        whi_q;
	logic [TW-1:0]        span_q;
	logic [3:0]           pos_q;
	logic signed [ccmsel_pkg::PROD_W-1:0] prod_q;
	logic signed [ccmsel_pkg::PROD_W-1:0] acc_q;
	logic signed [OW-1:0] res_q [ccmsel_pkg::NUM_COEF];

	logic                 acc_req;
	logic                 is_lookup;
	logic                 last_set;
	logic                 last_pos;
	logic [SET_W-1:0]     wr_set;
	logic                 wr_ok;
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        rd_addr;
	logic [SET_W-1:0]     rd_set;
	logic [TW-1:0]        w_mux;
	logic signed [ccmsel_pkg::WEIGHT_W-1:0] w_sgn;
	logic signed [ccmsel_pkg::NUM_W-1:0]    num;

	ccmsel_pkg::scan_res_t scan;
	logic                  div_done;
	logic signed [OW-1:0]  div_quot;

	logic                  single;
	logic [SET_W-1:0]      single_set;

	assign n_eff = (32'(set_count_q) > 32'(MAX_SETS)) ? CNT_W'(MAX_SETS) : CNT_W'(set_count_q);

	assign acc_req   = req.valid && req.ready;
	assign is_lookup = req.op == ccmsel_pkg::OP_LOOKUP;
	assign wr_set    = SET_W'(req.entry);
	assign wr_ok     = 32'(req.entry) < 32'(MAX_SETS);
	assign wr_addr   = AW'(AW'(wr_set) * AW'(ccmsel_pkg::NUM_COEF)) + AW'(req.coef_index);
	assign last_set  = (CNT_W'(idx_q) + CNT_W'(1)) == n_eff;
	assign last_pos  = pos_q == 4'(ccmsel_pkg::NUM_COEF - 1);
	assign rd_set    = (state_q == ccmsel_pkg::ST_RDB) ? hi_q : lo_q;
	assign rd_addr   = AW'(AW'(rd_set) * AW'(ccmsel_pkg::NUM_COEF))
		+ AW'(ccmsel_pkg::stored_index(pos_q));
	assign w_mux     = (state_q == ccmsel_pkg::ST_RDB) ? wlo_q : whi_q;
	assign w_sgn     = $signed({1'b0, w_mux});
	assign num       = ccmsel_pkg::NUM_W'(acc_q) + ccmsel_pkg::NUM_W'(prod_q);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_count_q  <= 4'd0;
			blend_mode_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				ccmsel_pkg::REG_SET_COUNT:  set_count_q  <= cfg.data;
				ccmsel_pkg::REG_BLEND_MODE: blend_mode_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_req && req.op == ccmsel_pkg::OP_WR_TEMP && wr_ok) begin
			tmem_q[wr_set] <= req.temperature;
		end
		tdat_q <= tmem_q[idx_q];
	end

	always_ff @(posedge clk) begin
		if (acc_req && req.op == ccmsel_pkg::OP_WR_COEF && wr_ok && req.coef_index <= 4'd8) begin
			cmem_q[wr_addr] <= req.coef_value;
		end
		cdat_q <= cmem_q[rd_addr];
	end

	ccmsel_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (state_q == ccmsel_pkg::ST_CMP),
		.first  (idx_q == '0),
		.idx    (ccmsel_pkg::SET_IDX_W'(idx_q)),
		.st     (tdat_q),
		.t      (t_q),
		.res    (scan)
	);

	ccmsel_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ccmsel_pkg::ST_SUM),
		.num    (num),
		.span   (span_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		single     = 1'b1;
		single_set = SET_W'(scan.lo);
		if (!blend_mode_q) begin
			single_set = SET_W'(scan.best);
		end else if (n_eff == CNT_W'(1)) begin
			single_set = '0;
		end else if (!scan.have_lo) begin
			single_set = SET_W'(scan.hi);
		end else if (scan.have_hi && scan.lo != scan.hi && scan.hi_t > scan.lo_t) begin
			single = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccmsel_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		rsp.valid = 1'b0;
		unique case (state_q)
			ccmsel_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && is_lookup) begin
					state_d = (n_eff == '0) ? ccmsel_pkg::ST_OUT : ccmsel_pkg::ST_SCAN;
				end
			end
			ccmsel_pkg::ST_SCAN:   state_d = ccmsel_pkg::ST_CMP;
			ccmsel_pkg::ST_CMP:    state_d = last_set ? ccmsel_pkg::ST_DECIDE : ccmsel_pkg::ST_SCAN;
			ccmsel_pkg::ST_DECIDE: state_d = ccmsel_pkg::ST_RDA;
			ccmsel_pkg::ST_RDA:    state_d = ccmsel_pkg::ST_RDB;
			ccmsel_pkg::ST_RDB:    state_d = ccmsel_pkg::ST_MULB;
			ccmsel_pkg::ST_MULB:   state_d = ccmsel_pkg::ST_SUM;
			ccmsel_pkg::ST_SUM:    state_d = ccmsel_pkg::ST_DIV;
			ccmsel_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = last_pos ? ccmsel_pkg::ST_OUT : ccmsel_pkg::ST_RDA;
				end
			end
			ccmsel_pkg::ST_OUT: begin
				rsp.valid = 1'b1;
				if (rsp.ready) begin
					state_d = ccmsel_pkg::ST_IDLE;
				end
			end
			default: state_d = ccmsel_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ccmsel_pkg::ST_IDLE: begin
				t_q   <= req.temperature;
				idx_q <= '0;
				pos_q <= 4'd0;
				for (int i = 0; i < ccmsel_pkg::NUM_COEF; i++) begin
					res_q[i] <= ccmsel_pkg::identity_coef(4'(i));
				end
			end
			ccmsel_pkg::ST_CMP: begin
				idx_q <= idx_q + SET_W'(1);
			end
			ccmsel_pkg::ST_DECIDE: begin
				if (single) begin
					lo_q   <= single_set;
					hi_q   <= single_set;
					wlo_q  <= TW'(1);
					whi_q  <= '0;
					span_q <= TW'(1);
				end else begin
					lo_q   <= SET_W'(scan.lo);
					hi_q   <= SET_W'(scan.hi);
					wlo_q  <= scan.hi_t - t_q;
					whi_q  <= t_q - scan.lo_t;
					span_q <= scan.hi_t - scan.lo_t;
				end
			end
			ccmsel_pkg::ST_RDB: begin
				prod_q <= cdat_q * w_sgn;
			end
			ccmsel_pkg::ST_MULB: begin
				acc_q  <= prod_q;
				prod_q <= cdat_q * w_sgn;
			end
			ccmsel_pkg::ST_DIV: begin
				if (div_done) begin
					res_q[pos_q] <= div_quot;
					pos_q        <= pos_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	assign rsp.coef_0 = res_q[0];
	assign rsp.coef_1 = res_q[1];
	assign rsp.coef_2 = res_q[2];
	assign rsp.coef_3 = res_q[3];
	assign rsp.coef_4 = res_q[4];
	assign rsp.coef_5 = res_q[5];
	assign rsp.coef_6 = res_q[6];
	assign rsp.coef_7 = res_q[7];
	assign rsp.coef_8 = res_q[8];

	a_ready_xor_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid))
		else $error("request taken while a result is pending");

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ccmsel_pkg::ST_DIV)
		else $error("divider finished outside the divide step");

	a_lookup_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && is_lookup) |=> !req.ready && !$past(rsp.valid))
		else $error("lookup transaction did not hold off the next request");

endmodule

/* hdl/ccmsel_scan.sv */
// Scan unit: walks the set temperatures one per step and tracks the nearest set
// and the lower and upper bracketing sets. Depends on ccmsel_pkg.
`timescale 1ns / 1ps

module ccmsel_scan (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic                                first,
	input  logic [ccmsel_pkg::SET_IDX_W-1:0]    idx,
	input  logic [ccmsel_pkg::TEMP_W-1:0]       st,
	input  logic [ccmsel_pkg::TEMP_W-1:0]       t,
	output ccmsel_pkg::scan_res_t               res
);

	ccmsel_pkg::scan_res_t          res_q;
	logic [ccmsel_pkg::TEMP_W-1:0]  bd_q;
	logic [ccmsel_pkg::TEMP_W-1:0]  gap;
	logic                           take_lo;
	logic                           take_hi;

	always_comb begin
		gap     = (st > t) ? st - t : t - st;
		take_lo = (st <= t) && (first || !res_q.have_lo || st > res_q.lo_t);
		take_hi = (st >= t) && (first || !res_q.have_hi || st < res_q.hi_t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
			bd_q  <= '0;
		end else if (step) begin
			if (first || gap < bd_q) begin
				bd_q       <= gap;
				res_q.best <= idx;
			end
			if (first) begin
				res_q.have_lo <= 1'b0;
				res_q.have_hi <= 1'b0;
			end
			if (take_lo) begin
				res_q.have_lo <= 1'b1;
				res_q.lo      <= idx;
				res_q.lo_t    <= st;
			end
			if (take_hi) begin
				res_q.have_hi <= 1'b1;
				res_q.hi      <= idx;
				res_q.hi_t    <= st;
			end
		end
	end

	assign res = res_q;

endmodule

/* hdl/ccmsel_div.sv */
// Iterative divider: rounds num / (span*64) half away from zero and saturates
// to 16 bits signed, one quotient bit per cycle. Depends on ccmsel_pkg.
`timescale 1ns / 1ps

module ccmsel_div (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	input  logic signed [ccmsel_pkg::NUM_W-1:0]       num,
	input  logic [ccmsel_pkg::TEMP_W-1:0]             span,
	output logic                                      done,
	output logic signed [ccmsel_pkg::COEF_OUT_W-1:0]  quot
);

	localparam int RW = ccmsel_pkg::REM_W;
	localparam int QW = ccmsel_pkg::QUOT_W;

	logic [RW-1:0]               rem_q;
	logic [RW-1:0]               dsh_q;
	logic [QW-1:0]               q_q;
	logic [4:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic                        neg_q;
	logic                        sat_q;
	logic [ccmsel_pkg::NUM_W-1:0] mag;
	logic [RW-1:0]               n_init;
	logic [RW-1:0]               d_two;
	logic                        ge;
	logic [QW-1:0]               q_lim;

	always_comb begin
		mag    = num[ccmsel_pkg::NUM_W-1] ? ccmsel_pkg::NUM_W'(-num) : ccmsel_pkg::NUM_W'(num);
		n_init = RW'({mag, 1'b0}) + RW'({span, 6'b0});
		d_two  = RW'({span, 7'b0});
		ge     = rem_q >= dsh_q;
		q_lim  = neg_q ? QW'(32768) : QW'(32767);
		if (sat_q || q_q > q_lim) begin
			quot = neg_q ? -16'sd32768 : 16'sd32767;
		end else begin
			quot = neg_q ? -$signed(16'(q_q)) : $signed(16'(q_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= n_init;
			dsh_q <= d_two << (QW - 1);
			q_q   <= '0;
			neg_q <= num[ccmsel_pkg::NUM_W-1];
			sat_q <= n_init >= (d_two << QW);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			q_q   <= {q_q[QW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;

endmodule
